FILE: rtl/csp_pkg.sv
`timescale 1ns / 1ps

package csp_pkg;

    // Input item: one frame to decode from or encode into.
    typedef struct packed {
        logic        kind;
        logic [28:0] can_id;
        logic [63:0] frame_data;
        logic [63:0] physical_value;
    } in_item_t;

    // Result item: one per input item.
    typedef struct packed {
        logic [63:0] frame_data_out;
        logic [63:0] decoded_value;
        logic        id_match;
        logic        clipped;
    } out_item_t;

    // Item kinds.
    localparam logic KIND_DECODE = 1'b0;
    localparam logic KIND_ENCODE = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_MATCH_ID      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_BIT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIELD_LENGTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SIGNED_MODE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE         = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERSE_SCALE = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_VALUE_OFFSET  = 3'd6;

    // Register values after reset.
    localparam logic [6:0]  FIELD_LENGTH_RESET = 7'd8;
    localparam logic [31:0] SCALE_RESET        = 32'd65536;

endpackage

FILE: rtl/can_signal_pack_unpack.sv
`timescale 1ns / 1ps

// CAN signal codec for one configured signal in Intel byte order. A decode item
// (kind 0) whose identifier matches gives raw*scale+offset, saturated to Q47.16;
// an encode item (kind 1) gives the payload with (value-offset)*inverse_scale,
// rounded half away from zero and saturated, written into the field. The block
// takes one item per clock while no result-side stall holds it back; the
// accepting edge loads the first of six pipeline stages, and the sixth stage
// feeds the output register. The 64x32 product is split into two 32x32
// partial products in one stage and summed in the next. Stalls on the result
// side fill bubbles first and then hold the pipeline. Configuration registers
// take effect on items accepted after the write if the user writes them only while
// no item is in flight; the block itself does not enforce this.
module can_signal_pack_unpack #(
    parameter int PAYLOAD_BITS = 64,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [csp_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [csp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  csp_pkg::in_item_t                    s_item,
    // result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output csp_pkg::out_item_t                   m_item
);

    localparam int NSTAGE   = 6;
    localparam int SH       = 2 * FRAC_BITS;
    localparam int HALF_POS = (SH > 0) ? (SH - 1) : 0;
    localparam logic [95:0] HALF  = (SH > 0) ? (96'd1 << HALF_POS) : 96'd0;
    localparam logic [63:0] PMASK = ~({64{1'b1}} << PAYLOAD_BITS);

    // Sideband that travels with every item.
    typedef struct packed {
        logic        kind;
        logic        id_hit;
        logic [63:0] data;
    } side_t;

    // Configuration registers.
    logic [28:0] match_id_reg;
    logic [5:0]  start_bit_reg;
    logic [6:0]  field_length_reg;
    logic        signed_mode_reg;
    logic [31:0] scale_reg;
    logic [31:0] inverse_scale_reg;
    logic [47:0] value_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_id_reg      <= '0;
            start_bit_reg     <= '0;
            field_length_reg  <= csp_pkg::FIELD_LENGTH_RESET;
            signed_mode_reg   <= 1'b0;
            scale_reg         <= csp_pkg::SCALE_RESET;
            inverse_scale_reg <= csp_pkg::SCALE_RESET;
            value_offset_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                csp_pkg::REG_MATCH_ID:      match_id_reg      <= cfg_wdata[28:0];
                csp_pkg::REG_START_BIT:     start_bit_reg     <= cfg_wdata[5:0];
                csp_pkg::REG_FIELD_LENGTH:  field_length_reg  <= cfg_wdata[6:0];
                csp_pkg::REG_SIGNED_MODE:   signed_mode_reg   <= cfg_wdata[0];
                csp_pkg::REG_SCALE:         scale_reg         <= cfg_wdata[31:0];
                csp_pkg::REG_INVERSE_SCALE: inverse_scale_reg <= cfg_wdata[31:0];
                csp_pkg::REG_VALUE_OFFSET:  value_offset_reg  <= cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    // Field geometry derived from the registers. A length of zero acts as one
    // and lengths above 64 act as 64.
    logic [6:0]  len_eff;
    logic [5:0]  len_m1;
    logic [63:0] fmask;
    logic [63:0] sign_pos;

    always_comb begin
        if (field_length_reg == 7'd0) begin
            len_eff = 7'd1;
        end else if (field_length_reg > 7'd64) begin
            len_eff = 7'd64;
        end else begin
            len_eff = field_length_reg;
        end
        len_m1   = 6'(len_eff - 7'd1);
        fmask    = ~({64{1'b1}} << len_eff);
        sign_pos = 64'd1 << len_m1;
    end

    // Pipeline control: a stage advances when it is empty or the next one does.
    logic [NSTAGE-1:0] vld_reg;
    logic              m_valid_reg;
    logic [NSTAGE-1:0] adv;
    logic              out_adv;

    always_comb begin
        out_adv             = !m_valid_reg || m_ready;
        adv[NSTAGE-1]       = !vld_reg[NSTAGE-1] || out_adv;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (out_adv) begin
                m_valid_reg <= vld_reg[NSTAGE-1];
            end
        end
    end

    // Sideband shift line.
    side_t side_reg [0:NSTAGE-1];
    side_t side_next;

    always_comb begin
        side_next.kind   = s_item.kind;
        side_next.id_hit = (s_item.kind == csp_pkg::KIND_DECODE)
                           && (s_item.can_id == match_id_reg);
        side_next.data   = s_item.frame_data;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            side_reg[0] <= side_next;
        end
        for (int i = 1; i < NSTAGE; i++) begin
            if (adv[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Stage 1: extract and sign-extend the field, or form value minus offset.
    // Both give a 65-bit two's complement operand.
    logic [64:0] s1_opnd_reg, s1_opnd_next;
    logic [63:0] ext_raw;
    logic        ext_neg;

    always_comb begin
        ext_raw = ((s_item.frame_data & PMASK) >> start_bit_reg) & fmask;
        ext_neg = signed_mode_reg && ((ext_raw & sign_pos) != 64'd0);
        if (ext_neg) begin
            ext_raw = ext_raw | ~fmask;
        end
        if (s_item.kind == csp_pkg::KIND_ENCODE) begin
            s1_opnd_next = {s_item.physical_value[63], s_item.physical_value}
                           - {{17{value_offset_reg[47]}}, value_offset_reg};
        end else begin
            s1_opnd_next = {ext_neg, ext_raw};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_opnd_reg <= s1_opnd_next;
        end
    end

    // Stage 2: magnitudes of both factors and the sign of the product.
    logic [63:0] s2_amag_reg, s2_amag_next;
    logic [31:0] s2_bmag_reg, s2_bmag_next;
    logic        s2_neg_reg, s2_neg_next;
    logic [64:0] opnd_neg;
    logic [31:0] bsel;

    always_comb begin
        opnd_neg     = ~s1_opnd_reg + 65'd1;
        s2_amag_next = s1_opnd_reg[64] ? opnd_neg[63:0] : s1_opnd_reg[63:0];
        bsel         = (side_reg[0].kind == csp_pkg::KIND_ENCODE) ? inverse_scale_reg
                                                                  : scale_reg;
        s2_bmag_next = bsel[31] ? (~bsel + 32'd1) : bsel;
        s2_neg_next  = s1_opnd_reg[64] ^ bsel[31];
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s2_amag_reg <= s2_amag_next;
            s2_bmag_reg <= s2_bmag_next;
            s2_neg_reg  <= s2_neg_next;
        end
    end

    // Stage 3: two 32x32 partial products.
    logic [63:0] s3_p0_reg, s3_p0_next;
    logic [63:0] s3_p1_reg, s3_p1_next;
    logic        s3_neg_reg;

    always_comb begin
        s3_p0_next = {32'd0, s2_amag_reg[31:0]}  * {32'd0, s2_bmag_reg};
        s3_p1_next = {32'd0, s2_amag_reg[63:32]} * {32'd0, s2_bmag_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s3_p0_reg  <= s3_p0_next;
            s3_p1_reg  <= s3_p1_next;
            s3_neg_reg <= s2_neg_reg;
        end
    end

    // Stage 4: sum of the partial products, the unsigned product.
    logic [95:0] s4_prod_reg, s4_prod_next;
    logic        s4_neg_reg;

    assign s4_prod_next = {32'd0, s3_p0_reg} + {s3_p1_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s4_prod_reg <= s4_prod_next;
            s4_neg_reg  <= s3_neg_reg;
        end
    end

    // Stage 5: decode applies the sign; encode rounds the magnitude to an
    // integer. A value that rounds to zero counts as positive.
    logic [96:0] s5_val_reg, s5_val_next;
    logic        s5_neg_reg, s5_neg_next;
    logic [95:0] rnd;
    logic [96:0] sprod;

    always_comb begin
        rnd   = (s4_prod_reg + HALF) >> SH;
        sprod = s4_neg_reg ? (~{1'b0, s4_prod_reg} + 97'd1) : {1'b0, s4_prod_reg};
        if (side_reg[3].kind == csp_pkg::KIND_ENCODE) begin
            s5_val_next = {1'b0, rnd};
            s5_neg_next = s4_neg_reg && (rnd != 96'd0);
        end else begin
            s5_val_next = sprod;
            s5_neg_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s5_val_reg <= s5_val_next;
            s5_neg_reg <= s5_neg_next;
        end
    end

    // Stage 6: decode adds the offset and saturates to 64 bits; encode
    // saturates the magnitude to the field range.
    logic [63:0] s6_val_reg, s6_val_next;
    logic        s6_neg_reg;
    logic        s6_clip_reg, s6_clip_next;
    logic [97:0] acc;
    logic [34:0] acc_top;
    logic [63:0] limit;
    logic        over;

    always_comb begin
        acc     = {s5_val_reg[96], s5_val_reg}
                  + {{50{value_offset_reg[47]}}, value_offset_reg};
        acc_top = acc[97:63];
        if (!signed_mode_reg) begin
            limit = fmask;
        end else if (s5_neg_reg) begin
            limit = sign_pos;
        end else begin
            limit = sign_pos - 64'd1;
        end
        over = (s5_val_reg[95:64] != 32'd0) || (s5_val_reg[63:0] > limit);

        s6_clip_next = 1'b0;
        if (side_reg[4].kind == csp_pkg::KIND_ENCODE) begin
            if (!signed_mode_reg && s5_neg_reg) begin
                s6_val_next  = 64'd0;
                s6_clip_next = 1'b1;
            end else if (over) begin
                s6_val_next  = limit;
                s6_clip_next = 1'b1;
            end else begin
                s6_val_next = s5_val_reg[63:0];
            end
        end else if ((&acc_top) || !(|acc_top)) begin
            s6_val_next = acc[63:0];
        end else if (acc[97]) begin
            s6_val_next = {1'b1, 63'd0};
        end else begin
            s6_val_next = {1'b0, {63{1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            s6_val_reg  <= s6_val_next;
            s6_neg_reg  <= s5_neg_reg;
            s6_clip_reg <= s6_clip_next;
        end
    end

    // Output stage: encode writes the field into the payload, leaving bits
    // outside the field and beyond the payload as they came.
    csp_pkg::out_item_t m_item_reg, m_item_next;
    logic [63:0] raw_bits;
    logic [63:0] wmask;

    always_comb begin
        raw_bits = (s6_neg_reg ? (~s6_val_reg + 64'd1) : s6_val_reg) & fmask;
        wmask    = (fmask << start_bit_reg) & PMASK;
        if (side_reg[5].kind == csp_pkg::KIND_ENCODE) begin
            m_item_next.frame_data_out = (side_reg[5].data & ~wmask)
                                         | ((raw_bits << start_bit_reg) & wmask);
            m_item_next.decoded_value  = 64'd0;
            m_item_next.id_match       = 1'b0;
            m_item_next.clipped        = s6_clip_reg;
        end else begin
            m_item_next.frame_data_out = side_reg[5].data;
            m_item_next.decoded_value  = side_reg[5].id_hit ? s6_val_reg : 64'd0;
            m_item_next.id_match       = side_reg[5].id_hit;
            m_item_next.clipped        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_item = m_item_reg;

endmodule

FILE: rtl/csp_checker.sv
`timescale 1ns / 1ps

module csp_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input csp_pkg::out_item_t     m_item
);

    // A stalled result item holds its place and its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed or vanished while stalled");

    // Reset empties the pipeline.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item present right after reset");

    // With the output empty, every stage can move, so the input is open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while the output is empty");

    // A decoded value only comes with a matching identifier.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.id_match |-> m_item.decoded_value == 64'd0)
        else $error("decoded value without identifier match");

    // Clipping belongs to encode items, which never report a match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.clipped |-> !m_item.id_match)
        else $error("clip flag on a decode item");

endmodule

bind can_signal_pack_unpack csp_checker u_csp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

FILE: sim/tb_can_signal_pack_unpack.sv
`timescale 1ns / 1ps

module tb_can_signal_pack_unpack;

    localparam int          FRAC_BITS   = 16;
    localparam int          STALL_LIMIT = 2000;
    localparam int          MAX_REPORTS = 50;
    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_ITEMS = 90;
    localparam logic [csp_pkg::CFG_ADDR_W-1:0] REG_NONE = 3'd7;

    // Local copy of the signal description held by the block.
    typedef struct packed {
        logic [28:0] match_id;
        logic [5:0]  start_bit;
        logic [6:0]  field_length;
        logic        signed_mode;
        logic [31:0] scale;
        logic [31:0] inverse_scale;
        logic [47:0] value_offset;
    } signal_cfg_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [csp_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [csp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    csp_pkg::in_item_t              s_item    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    csp_pkg::out_item_t             m_item;

    signal_cfg_t        sig_cfg;
    csp_pkg::out_item_t results_due[$];
    int                 errors      = 0;
    int                 idle_cycles = 0;
    int                 hold_cycles = 0;
    bit                 no_gaps     = 1'b0;
    int                 n_hits      = 0;
    int                 n_misses    = 0;
    int                 n_encodes   = 0;
    int                 n_clips     = 0;
    int                 n_settings  = 0;

    can_signal_pack_unpack #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #5 aclk = ~aclk;

    // Field lengths of zero act as one bit, lengths past 64 act as 64.
    function automatic int unsigned field_bits(logic [6:0] n);
        if (n == 0) return 1;
        if (n > 64) return 64;
        return 32'(n);
    endfunction

    // Expected result of one item: field extraction and scaling for a decode,
    // rounding, saturation and insertion for an encode.
    function automatic csp_pkg::out_item_t convert_item(csp_pkg::in_item_t item,
                                                        signal_cfg_t c);
        csp_pkg::out_item_t    r;
        int unsigned           len;
        int unsigned           sb;
        logic [63:0]           fmask;
        logic [63:0]           raw;
        logic [63:0]           wmask;
        logic [63:0]           mag;
        logic [63:0]           limit;
        logic [63:0]           rawbits;
        logic [31:0]           imag;
        logic                  rneg;
        logic                  dneg;
        logic                  ineg;
        logic                  neg;
        logic                  clip;
        logic signed [64:0]    raw_s;
        logic signed [64:0]    diff;
        logic [64:0]           dmag;
        logic signed [127:0]   raw_w;
        logic signed [127:0]   scale_w;
        logic signed [127:0]   offset_w;
        logic signed [127:0]   acc;
        logic [127:0]          prod;

        len   = field_bits(c.field_length);
        sb    = 32'(c.start_bit);
        fmask = (64'd1 << len) - 64'd1;
        r.frame_data_out = item.frame_data;
        r.decoded_value  = '0;
        r.id_match       = 1'b0;
        r.clipped        = 1'b0;

        if (item.kind == csp_pkg::KIND_DECODE) begin
            if (item.can_id == c.match_id) begin
                // Bits beyond the payload read as zero, sign bit included.
                raw  = (item.frame_data >> sb) & fmask;
                rneg = c.signed_mode && raw[len-1];
                if (rneg) raw = raw | ~fmask;
                raw_s    = {rneg, raw};
                raw_w    = 128'(raw_s);
                scale_w  = 128'($signed(c.scale));
                offset_w = 128'($signed(c.value_offset));
                acc      = raw_w * scale_w + offset_w;
                if (acc[127:63] != {65{acc[127]}}) begin
                    r.decoded_value = acc[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else begin
                    r.decoded_value = acc[63:0];
                end
                r.id_match = 1'b1;
            end
        end else begin
            // Exact difference, magnitude product, round half away from zero.
            diff = 65'($signed(item.physical_value)) - 65'($signed(c.value_offset));
            dneg = diff[64];
            dmag = dneg ? -diff : diff;
            ineg = c.inverse_scale[31];
            imag = ineg ? (32'd0 - c.inverse_scale) : c.inverse_scale;
            prod = {63'd0, dmag} * {96'd0, imag};
            prod = (prod + (128'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
            neg  = (dneg != ineg) && (prod != 0);
            clip = 1'b0;
            if (!c.signed_mode) begin
                limit = fmask;
                if (neg) begin
                    mag  = '0;
                    clip = 1'b1;
                end else if (prod > {64'd0, limit}) begin
                    mag  = limit;
                    clip = 1'b1;
                end else begin
                    mag = prod[63:0];
                end
            end else begin
                limit = neg ? (64'd1 << (len - 1)) : ((64'd1 << (len - 1)) - 64'd1);
                if (prod > {64'd0, limit}) begin
                    mag  = limit;
                    clip = 1'b1;
                end else begin
                    mag = prod[63:0];
                end
            end
            rawbits = (neg ? -mag : mag) & fmask;
            wmask   = fmask << sb;
            r.frame_data_out = (item.frame_data & ~wmask) | ((rawbits << sb) & wmask);
            r.clipped        = clip;
        end
        return r;
    endfunction

    function automatic csp_pkg::in_item_t make_item(logic kind, logic [28:0] id,
                                                    logic [63:0] data, logic [63:0] pv);
        csp_pkg::in_item_t item;
        item.kind           = kind;
        item.can_id         = id;
        item.frame_data     = data;
        item.physical_value = pv;
        return item;
    endfunction

    function automatic int unsigned idle_draw();
        return no_gaps ? 0 : $urandom_range(0, 4);
    endfunction

    // Random item shaped by the current setting: most decodes carry the matching
    // identifier, most encodes aim at a raw value near the field range.
    function automatic csp_pkg::in_item_t random_item();
        csp_pkg::in_item_t   item;
        int unsigned         bits;
        logic signed [63:0]  t64;
        logic signed [127:0] target;
        logic signed [127:0] q;
        int unsigned         pick;

        item.kind           = $urandom_range(0, 1) ? csp_pkg::KIND_ENCODE
                                                   : csp_pkg::KIND_DECODE;
        item.frame_data     = {$urandom, $urandom};
        item.physical_value = {$urandom, $urandom};
        pick = $urandom_range(0, 7);
        if (pick < 5) begin
            item.can_id = sig_cfg.match_id;
        end else if (pick < 7) begin
            item.can_id = 29'($urandom);
        end else begin
            item.can_id = sig_cfg.match_id ^ (29'd1 << $urandom_range(0, 28));
        end
        if (item.kind == csp_pkg::KIND_ENCODE && $urandom_range(0, 3) != 0) begin
            bits = field_bits(sig_cfg.field_length);
            if (bits > 62) bits = 62;
            t64    = $signed({$urandom, $urandom}) >>> (63 - bits);
            target = 128'(t64);
            if (sig_cfg.inverse_scale == 0) begin
                q = target <<< FRAC_BITS;
            end else begin
                q = (target <<< (2 * FRAC_BITS)) / $signed(sig_cfg.inverse_scale);
            end
            item.physical_value = q[63:0]
                + {{16{sig_cfg.value_offset[47]}}, sig_cfg.value_offset};
        end
        return item;
    endfunction

    // Offers one item after a random gap and records its expected result once
    // the block takes it.
    task automatic send_item(input csp_pkg::in_item_t item);
        csp_pkg::out_item_t due;
        int unsigned        gap;
        gap = idle_draw();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= item;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        due = convert_item(item, sig_cfg);
        results_due.push_back(due);
        if (item.kind == csp_pkg::KIND_DECODE) begin
            if (due.id_match) n_hits++;
            else n_misses++;
        end else begin
            n_encodes++;
            if (due.clipped) n_clips++;
        end
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
    endtask

    // Writes one register; bits above the register width carry random junk.
    task automatic write_reg(input logic [csp_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [47:0] value);
        logic [47:0] keep;
        logic [47:0] junk;
        junk = {16'($urandom), 32'($urandom)};
        case (idx)
            csp_pkg::REG_MATCH_ID: begin
                keep = 48'h0000_1FFF_FFFF;
                sig_cfg.match_id = value[28:0];
            end
            csp_pkg::REG_START_BIT: begin
                keep = 48'h0000_0000_003F;
                sig_cfg.start_bit = value[5:0];
            end
            csp_pkg::REG_FIELD_LENGTH: begin
                keep = 48'h0000_0000_007F;
                sig_cfg.field_length = value[6:0];
            end
            csp_pkg::REG_SIGNED_MODE: begin
                keep = 48'h0000_0000_0001;
                sig_cfg.signed_mode = value[0];
            end
            csp_pkg::REG_SCALE: begin
                keep = 48'h0000_FFFF_FFFF;
                sig_cfg.scale = value[31:0];
            end
            csp_pkg::REG_INVERSE_SCALE: begin
                keep = 48'h0000_FFFF_FFFF;
                sig_cfg.inverse_scale = value[31:0];
            end
            csp_pkg::REG_VALUE_OFFSET: begin
                keep = 48'hFFFF_FFFF_FFFF;
                sig_cfg.value_offset = value;
            end
            default: begin
                keep = '0;
            end
        endcase
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= (value & keep) | (junk & ~keep);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Random setting for one phase; the first phases pin the length extremes.
    task automatic randomize_signal(input int phase);
        logic [6:0]  len;
        logic [5:0]  sb;
        logic        sgn;
        logic [31:0] scl;
        logic [31:0] inv;
        logic [47:0] off;

        case (phase)
            0: len = 7'd64;
            1: len = 7'd1;
            2: len = 7'd0;
            3: len = 7'(65 + $urandom_range(0, 62));
            default: begin
                case ($urandom_range(0, 2))
                    0: len = 7'($urandom_range(1, 8));
                    1: len = 7'($urandom_range(9, 32));
                    default: len = 7'($urandom_range(33, 64));
                endcase
            end
        endcase
        sb  = (phase == 0) ? 6'd0 : (phase == 1) ? 6'd63 : 6'($urandom_range(0, 63));
        sgn = (phase < 2) ? 1'b1 : 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: scl = 32'd65536;
            1: scl = $urandom;
            2: scl = 32'($urandom_range(0, 1 << 20));
            default: scl = -32'($urandom_range(1, 1 << 20));
        endcase
        case ($urandom_range(0, 3))
            0: inv = 32'd65536;
            1: inv = $urandom;
            2: inv = 32'($urandom_range(1, 1 << 20));
            default: inv = -32'($urandom_range(1, 1 << 20));
        endcase
        case ($urandom_range(0, 2))
            0: off = '0;
            1: off = {16'($urandom), 32'($urandom)};
            default: off = 48'($urandom_range(0, 1 << 24)) - 48'd8388608;
        endcase
        write_reg(csp_pkg::REG_MATCH_ID, 48'($urandom));
        write_reg(csp_pkg::REG_START_BIT, 48'(sb));
        write_reg(csp_pkg::REG_FIELD_LENGTH, 48'(len));
        write_reg(csp_pkg::REG_SIGNED_MODE, 48'(sgn));
        write_reg(csp_pkg::REG_SCALE, 48'(scl));
        write_reg(csp_pkg::REG_INVERSE_SCALE, 48'(inv));
        write_reg(csp_pkg::REG_VALUE_OFFSET, off);
        n_settings++;
    endtask

    // Values after reset: an 8-bit unsigned field at bit 0, unit scales.
    task automatic test_reset_values();
        n_settings++;
        send_item(make_item(csp_pkg::KIND_DECODE, 29'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                            64'd0));
        send_item(make_item(csp_pkg::KIND_DECODE, 29'h1FFF_FFFF, 64'h0123_4567_89AB_CDEF,
                            64'd0));
        // 200.5 rounds up to 201.
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'd0, 64'h0000_0000_00C8_8000));
        // A negative value in an unsigned field clips to zero.
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                            -64'sd196608));
        // -0.25 rounds to zero and is not a clip.
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'hA5A5_A5A5_A5A5_A5A5,
                            -64'sd16384));
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF));
        drain();
    endtask

    // Hand-picked settings at the edges of every register and field.
    task automatic test_directed_cases();
        // Signed field at the last payload bit: its sign bit lies outside.
        write_reg(csp_pkg::REG_MATCH_ID, 48'h0000_1FFF_FFFF);
        write_reg(csp_pkg::REG_START_BIT, 48'd63);
        write_reg(csp_pkg::REG_SIGNED_MODE, 48'd1);
        write_reg(csp_pkg::REG_SCALE, 48'h0000_FFFF_0000);
        write_reg(csp_pkg::REG_VALUE_OFFSET, 48'h0000_0002_8000);
        n_settings++;
        send_item(make_item(csp_pkg::KIND_DECODE, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                            64'd0));
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'd0, 64'h0000_0000_0001_8000));
        // -2.5 rounds away from zero to -3.
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'd0, 64'd0));
        drain();

        // Full 64-bit signed field with extreme scales and offset.
        write_reg(csp_pkg::REG_START_BIT, 48'd0);
        write_reg(csp_pkg::REG_FIELD_LENGTH, 48'd64);
        write_reg(csp_pkg::REG_SCALE, 48'h0000_7FFF_FFFF);
        write_reg(csp_pkg::REG_INVERSE_SCALE, 48'h0000_8000_0000);
        write_reg(csp_pkg::REG_VALUE_OFFSET, 48'h7FFF_FFFF_FFFF);
        n_settings++;
        send_item(make_item(csp_pkg::KIND_DECODE, 29'h1FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                            64'd0));
        send_item(make_item(csp_pkg::KIND_DECODE, 29'h1FFF_FFFF, 64'h8000_0000_0000_0000,
                            64'd0));
        send_item(make_item(csp_pkg::KIND_DECODE, 29'd0, 64'h8000_0000_0000_0000, 64'd0));
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'd0, 64'h8000_0000_0000_0000));
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF));
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                            64'h0000_7FFF_FFFF_FFFF));
        drain();

        // Zero length acts as a single unsigned bit; most negative scale and offset.
        write_reg(csp_pkg::REG_MATCH_ID, 48'd0);
        write_reg(csp_pkg::REG_START_BIT, 48'd5);
        write_reg(csp_pkg::REG_FIELD_LENGTH, 48'd0);
        write_reg(csp_pkg::REG_SIGNED_MODE, 48'd0);
        write_reg(csp_pkg::REG_SCALE, 48'h0000_8000_0000);
        write_reg(csp_pkg::REG_INVERSE_SCALE, 48'd65536);
        write_reg(csp_pkg::REG_VALUE_OFFSET, 48'h8000_0000_0000);
        n_settings++;
        send_item(make_item(csp_pkg::KIND_DECODE, 29'd0, 64'h0000_0000_0000_0020, 64'd0));
        send_item(make_item(csp_pkg::KIND_DECODE, 29'd0, 64'hFFFF_FFFF_FFFF_FFDF, 64'd0));
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'd0, 64'hFFFF_8000_0001_0000));
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'd0, 64'hFFFF_8000_0002_0000));
        drain();

        // Lengths above 64 act as 64, so half the field lies past the payload.
        write_reg(csp_pkg::REG_FIELD_LENGTH, 48'd127);
        write_reg(csp_pkg::REG_START_BIT, 48'd32);
        write_reg(csp_pkg::REG_SCALE, 48'd65536);
        write_reg(csp_pkg::REG_VALUE_OFFSET, 48'd0);
        n_settings++;
        send_item(make_item(csp_pkg::KIND_DECODE, 29'd0, 64'hDEAD_BEEF_0123_4567, 64'd0));
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'hCAFE_F00D_8765_4321,
                            64'h0000_1234_5678_0000));
        drain();

        // A write to an unused index changes nothing.
        write_reg(REG_NONE, 48'hFFFF_FFFF_FFFF);
        send_item(make_item(csp_pkg::KIND_DECODE, 29'd0, 64'h1357_9BDF_0000_0000, 64'd0));
        drain();

        // Signed byte at bit 60: the top four bits and the sign fall outside.
        write_reg(csp_pkg::REG_FIELD_LENGTH, 48'd8);
        write_reg(csp_pkg::REG_START_BIT, 48'd60);
        write_reg(csp_pkg::REG_SIGNED_MODE, 48'd1);
        n_settings++;
        send_item(make_item(csp_pkg::KIND_ENCODE, 29'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                            -64'sd13107200));
        send_item(make_item(csp_pkg::KIND_DECODE, 29'd0, 64'hF000_0000_0000_0000, 64'd0));
        drain();
    endtask

    // Several random settings with random items, one phase without any idling.
    task automatic test_random_phases();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            randomize_signal(phase);
            no_gaps = (phase == 5);
            repeat (PHASE_ITEMS) send_item(random_item());
        end
        drain();
        no_gaps = 1'b0;
    endtask

    // The result side stalls for a long stretch while items keep coming, so
    // the pipeline fills and the input side has to stall.
    task automatic test_backpressure();
        no_gaps     = 1'b1;
        hold_cycles = 80;
        repeat (40) send_item(random_item());
        drain();
        no_gaps = 1'b0;
    endtask

    function automatic void flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        end
    endfunction

    // Result side: random ready gaps, the long hold when asked, and a
    // field-by-field comparison of each item with the oldest expectation.
    initial begin : result_checker
        csp_pkg::out_item_t want;
        csp_pkg::out_item_t got;
        int unsigned        gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = idle_draw();
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_cycles = 0;
                m_ready <= 1'b1;
            end else if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            got = m_item;
            if (results_due.size() == 0) begin
                flag_mismatch("unexpected item, frame_data_out", '0, got.frame_data_out);
            end else begin
                want = results_due.pop_front();
                if (got.frame_data_out !== want.frame_data_out)
                    flag_mismatch("frame_data_out", want.frame_data_out, got.frame_data_out);
                if (got.decoded_value !== want.decoded_value)
                    flag_mismatch("decoded_value", want.decoded_value, got.decoded_value);
                if (got.id_match !== want.id_match)
                    flag_mismatch("id_match", 64'(want.id_match), 64'(got.id_match));
                if (got.clipped !== want.clipped)
                    flag_mismatch("clipped", 64'(want.clipped), 64'(got.clipped));
            end
        end
    end

    // Count cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
        $display("can_signal_pack_unpack: mismatch");
        $finish;
    end

    initial begin : main_sequence
        sig_cfg = '{match_id: '0, start_bit: '0,
                    field_length: csp_pkg::FIELD_LENGTH_RESET,
                    signed_mode: 1'b0, scale: csp_pkg::SCALE_RESET,
                    inverse_scale: csp_pkg::SCALE_RESET, value_offset: '0};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_directed_cases();
        test_random_phases();
        test_backpressure();

        drain();
        repeat (16) @(posedge aclk);
        if (results_due.size() != 0) begin
            errors++;
            $display("%0t ns: %0d results never arrived", $time, results_due.size());
        end

        $display("Ran %0d decode items (%0d with a foreign identifier) and %0d encode items,",
                 n_hits + n_misses, n_misses, n_encodes);
        $display("%0d of them clipped, over %0d signal settings with one long result stall.",
                 n_clips, n_settings);
        if (errors == 0) begin
            $display("can_signal_pack_unpack: match");
        end else begin
            $display("can_signal_pack_unpack: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/csp_pkg.sv
rtl/can_signal_pack_unpack.sv
rtl/csp_checker.sv
sim/tb_can_signal_pack_unpack.sv
